>>> design/mqs_pkg.sv
// Shared types and codes for the multi-queue shared store.
// No dependencies; imported by mqs_ctrl, mqs_dp and the top level.
package mqs_pkg;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		REQ_PUSH = 1'b0,
		REQ_POP  = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic               req_type;
		logic [1:0]         queue_id;
		logic signed [31:0] push_value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] pop_value;
		logic               now_full;
		logic               now_empty;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FETCH
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic fetch;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

>>> design/mqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/mqs_ctrl.sv
// Controller state machine: sequences accept, execute and fetch steps.
// Depends on mqs_pkg.
module mqs_ctrl
	import mqs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = stat.out_free;
				if (req_valid && stat.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_FETCH;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/mqs_dp.sv
// Datapath: per-queue head, tail and count registers, slot RAM, output register.
// Depends on mqs_pkg and mqs_ram.
module mqs_dp
	import mqs_pkg::*;
#(
	parameter int TOTAL_SLOTS = 16,
	parameter int QUEUE_COUNT = 4,
	parameter int DATA_WIDTH  = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	output rsp_t     rsp,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat
);

	localparam int PART = TOTAL_SLOTS / QUEUE_COUNT;
	localparam int PW   = (PART > 1) ? $clog2(PART) : 1;
	localparam int CW   = (PART > 0) ? $clog2(PART + 1) : 1;
	localparam int AW   = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
	localparam int QW   = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam logic [PW-1:0] IDX_LAST = PW'((PART > 0) ? PART - 1 : 0);
	localparam logic [CW:0]   PART_C   = (CW + 1)'(PART);

	function automatic logic [QW-1:0] wrap_queue(input logic [1:0] id);
		int v;
		v = int'(id);
		for (int i = 0; i < 4; i++) begin
			if (v >= QUEUE_COUNT) begin
				v = v - QUEUE_COUNT;
			end
		end
		return QW'(v);
	endfunction

	function automatic logic [PW-1:0] advance(input logic [PW-1:0] idx);
		return (idx == IDX_LAST) ? '0 : idx + 1'b1;
	endfunction

	logic [PW-1:0] head_q  [QUEUE_COUNT];
	logic [PW-1:0] tail_q  [QUEUE_COUNT];
	logic [CW-1:0] count_q [QUEUE_COUNT];

	logic                  op_s1;
	logic [QW-1:0]         q_s1;
	logic [DATA_WIDTH-1:0] value_s1;

	logic [1:0] status_q;
	logic       pop_q;
	logic       full_q;
	logic       empty_q;
	logic       out_valid_q;
	rsp_t       rsp_q;

	logic [CW-1:0]         cnt;
	logic                  is_full;
	logic                  is_empty;
	logic                  do_push;
	logic                  do_pop;
	logic [CW-1:0]         cnt_next;
	logic [AW-1:0]         waddr;
	logic [AW-1:0]         raddr;
	logic [DATA_WIDTH-1:0] rdata;

	assign cnt      = count_q[q_s1];
	assign is_full  = {1'b0, cnt} >= PART_C;
	assign is_empty = (cnt == '0);
	assign do_push  = cmd.exec && (op_s1 == REQ_PUSH) && !is_full;
	assign do_pop   = cmd.exec && (op_s1 == REQ_POP) && !is_empty;
	assign cnt_next = do_push ? cnt + 1'b1 : (do_pop ? cnt - 1'b1 : cnt);
	assign waddr    = AW'(int'(q_s1) * PART + int'(tail_q[q_s1]));
	assign raddr    = AW'(int'(q_s1) * PART + int'(head_q[q_s1]));

	mqs_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(TOTAL_SLOTS)
	) u_store (
		.clk  (clk),
		.we   (do_push),
		.waddr(waddr),
		.wdata(value_s1),
		.raddr(raddr),
		.rdata(rdata)
	);

	// capture the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_s1    <= req.req_type;
			q_s1     <= wrap_queue(req.queue_id);
			value_s1 <= DATA_WIDTH'($unsigned(req.push_value));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_COUNT; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			count_q[q_s1] <= cnt_next;
			if (do_push) begin
				tail_q[q_s1] <= advance(tail_q[q_s1]);
			end
			if (do_pop) begin
				head_q[q_s1] <= advance(head_q[q_s1]);
			end
		end
	end

	// step results, held until the read data arrives
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			pop_q   <= do_pop;
			full_q  <= {1'b0, cnt_next} >= PART_C;
			empty_q <= (cnt_next == '0);
			if (op_s1 == REQ_PUSH && is_full) begin
				status_q <= STATUS_FULL;
			end else if (op_s1 == REQ_POP && is_empty) begin
				status_q <= STATUS_EMPTY;
			end else begin
				status_q <= STATUS_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			rsp_q.status    <= status_q;
			rsp_q.pop_value <= pop_q ? $signed(32'(rdata)) : '0;
			rsp_q.now_full  <= full_q;
			rsp_q.now_empty <= empty_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fetch) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp           = rsp_q;
	assign rsp_valid     = out_valid_q;
	assign stat.out_free = !out_valid_q || rsp_ready;

endmodule

>>> design/multi_queue_shared_store.sv
// Several FIFO queues sharing one slot RAM, each with a fixed equal partition.
// Top level; depends on mqs_pkg, mqs_ctrl and mqs_dp.
//
// Request channel (req, req_valid, req_ready): push a value to a queue or pop
// its oldest value. Response channel (rsp, rsp_valid, rsp_ready): one response
// per request with status (ok, full, empty), the popped value (zero unless a
// pop succeeded) and the queue's full and empty flags after the operation.
// A queue id beyond the queue count wraps around the queue count.
//
// Timing: a request is taken in the idle state, updates the pointers and
// addresses the slot RAM in the execute state, and loads the response register
// in the fetch state, after which rsp_valid rises. One request is in flight at a
// time; the fetch state waits for the registered RAM read of a pop.
// The response register frees the input side: a new request is taken while the
// previous response is being taken in the same cycle. If the receiver stalls,
// the response holds and req_ready stays low until it is taken.
// Reset empties every queue at once; slot contents need no clearing since a
// slot is only read after it was written.
module multi_queue_shared_store
	import mqs_pkg::*;
#(
	parameter int TOTAL_SLOTS = 16,
	parameter int QUEUE_COUNT = 4,
	parameter int DATA_WIDTH  = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic req_valid,
	output logic req_ready,
	output rsp_t rsp,
	output logic rsp_valid,
	input  logic rsp_ready
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	mqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mqs_dp #(
		.TOTAL_SLOTS(TOTAL_SLOTS),
		.QUEUE_COUNT(QUEUE_COUNT),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule
